[rtl/core/stpg_pkg.sv]
// Package for the stepper trapezoid pulse generator: field widths, operation and
// register codes, sequencer states and the structs between the top level and the
// shared multiply-divide unit. No dependencies.
package stpg_pkg;

	// Field and state widths.
	localparam int COUNT_BITS = 32;
	localparam int DELAY_BITS = 24;
	localparam int OUT_W      = 32;
	localparam int OP_W       = 3;
	localparam int IN_CNT_W   = 32;
	localparam int IN_DLY_W   = 24;
	localparam int RAMP_W     = 16;
	localparam int MULT_W     = 8;
	localparam int PW_W       = 10;
	localparam int STATUS_W   = 2;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_START_NUM  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_DEN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_LEN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_W    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ACT_LEVEL  = 3'd4;

	// Configuration reset values.
	localparam logic [MULT_W-1:0] RST_START_NUM = 8'd3;
	localparam logic [MULT_W-1:0] RST_START_DEN = 8'd1;
	localparam logic [RAMP_W-1:0] RST_RAMP_LEN  = 16'd200;
	localparam logic [PW_W-1:0]   RST_PULSE_W   = 10'd5;

	// State reset values.
	localparam logic [DELAY_BITS-1:0] RST_NOM_DELAY = DELAY_BITS'(1000);
	localparam logic [OUT_W-1:0]      RST_DELAY     = OUT_W'(1000);

	// All ones step count: move with no deceleration ramp.
	localparam logic [COUNT_BITS-1:0] COUNT_ALL = '1;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
	localparam logic [OP_W-1:0] OP_START_PROF = 3'd1;
	localparam logic [OP_W-1:0] OP_START_CONT = 3'd2;
	localparam logic [OP_W-1:0] OP_ARM_STOP   = 3'd3;
	localparam logic [OP_W-1:0] OP_STOP       = 3'd4;

	// Command status codes.
	typedef enum logic [STATUS_W-1:0] {
		CS_OK      = 2'd0,
		CS_BUSY    = 2'd1,
		CS_IGNORED = 2'd2
	} cmd_status_t;

	// Multiply-divide unit: floor(a * b / c).
	localparam int MD_A_W   = 32;
	localparam int MD_B_W   = 16;
	localparam int MD_P_W   = MD_A_W + MD_B_W;
	localparam int MD_CNT_W = $clog2(MD_P_W);

	typedef struct packed {
		logic              start;
		logic [MD_A_W-1:0] a;
		logic [MD_B_W-1:0] b;
		logic [MD_B_W-1:0] c;
	} md_req_t;

	typedef struct packed {
		logic              done;
		logic [MD_P_W-1:0] quo;
	} md_rsp_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} md_state_t;

	// Top-level sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WAIT_START,
		ST_RC_ACC,
		ST_WAIT_ACC,
		ST_RC_REM,
		ST_WAIT_REM,
		ST_FINISH,
		ST_OUT
	} ctl_state_t;

endpackage

[rtl/core/stpg_if.sv]
// Handshake channel interfaces of the stepper trapezoid pulse generator:
// command input, result output and configuration write.
// Depends on stpg_pkg for the field widths.
interface stpg_cmd_if;
	import stpg_pkg::*;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [IN_CNT_W-1:0] step_count;
	logic [IN_DLY_W-1:0] delay_us;

	modport source (output valid, output op, output step_count, output delay_us,
		input ready);
	modport sink (input valid, input op, input step_count, input delay_us,
		output ready);
endinterface

interface stpg_res_if;
	import stpg_pkg::*;
	logic                valid;
	logic                ready;
	logic                step_pin;
	logic                running;
	logic                move_done;
	logic [STATUS_W-1:0] cmd_status;
	logic [OUT_W-1:0]    steps_done;
	logic [OUT_W-1:0]    delay_now;
	logic [OUT_W-1:0]    lifetime_steps;

	modport source (output valid, output step_pin, output running, output move_done,
		output cmd_status, output steps_done, output delay_now, output lifetime_steps,
		input ready);
	modport sink (input valid, input step_pin, input running, input move_done,
		input cmd_status, input steps_done, input delay_now, input lifetime_steps,
		output ready);
endinterface

interface stpg_cfg_if;
	import stpg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/stepper_trapezoid_pulse_gen.sv]
// Stepper trapezoid pulse generator, top level. A tick or a command that needs no
// ramp arithmetic passes the decode and output states before it loads the result
// register. Each ramp delay term is one pass through the shared multiply-divide
// unit: a step end adds up to two terms, a profiled start up to three. One item is
// in work at a time; the next is taken while a result waits. Reset (arst_n,
// asynchronous) sets the control, configuration and motion registers to their
// defaults at once.
module stepper_trapezoid_pulse_gen (
	input  logic clk,
	input  logic arst_n,
	stpg_cfg_if.sink   cfg,
	stpg_cmd_if.sink   cmd,
	stpg_res_if.source res
);
	import stpg_pkg::*;

	// Configuration registers.
	logic [MULT_W-1:0] start_num_q;
	logic [MULT_W-1:0] start_den_q;
	logic [RAMP_W-1:0] ramp_def_q;
	logic [PW_W-1:0]   pulse_w_q;
	logic              act_level_q;

	// Motion state.
	logic                  is_active_q;
	logic                  pulse_on_q;
	logic                  endless_q;
	logic [COUNT_BITS-1:0] target_q;
	logic [COUNT_BITS-1:0] done_steps_q;
	logic [DELAY_BITS-1:0] nominal_q;
	logic [OUT_W-1:0]      cur_delay_q;
	logic [OUT_W-1:0]      start_delay_q;
	logic [RAMP_W-1:0]     ramp_len_q;
	logic [OUT_W-1:0]      elapsed_q;
	logic [OUT_W-1:0]      total_q;
	logic [OUT_W-1:0]      tgt_q;
	cmd_status_t           status_q;
	logic                  move_done_q;

	// Held command.
	logic [OP_W-1:0]       op_q;
	logic [COUNT_BITS-1:0] cnt_in_q;
	logic [DELAY_BITS-1:0] dly_in_q;

	// Result register.
	logic                res_valid_q;
	logic                res_pin_q;
	logic                res_running_q;
	logic                res_done_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [OUT_W-1:0]    res_steps_q;
	logic [OUT_W-1:0]    res_delay_q;
	logic [OUT_W-1:0]    res_total_q;

	ctl_state_t state_q, state_d;
	md_req_t    md_req;
	md_rsp_t    md_rsp;

	logic [DELAY_BITS-1:0] d_eff;
	logic [OUT_W-1:0]      d_ext;
	logic [MULT_W-1:0]     den_eff;
	logic [OUT_W-1:0]      elapsed_inc;
	logic [COUNT_BITS-1:0] done_inc;
	logic                  tick_start;
	logic                  tick_end;
	logic                  tick_finish;
	logic                  tick_recompute;
	logic [COUNT_BITS-1:0] half_n;
	logic [RAMP_W-1:0]     ramp_min;
	logic [RAMP_W-1:0]     ramp_set;
	logic [COUNT_BITS:0]   arm_sum;
	logic [COUNT_BITS-1:0] arm_target;
	logic [RAMP_W-1:0]     r_eff;
	logic [RAMP_W-1:0]     acc_prog;
	logic [COUNT_BITS-1:0] rem_full;
	logic [RAMP_W-1:0]     rem_prog;
	logic [OUT_W-1:0]      nom_ext;
	logic                  sd_above;
	logic [OUT_W-1:0]      delta;
	logic                  acc_trivial;
	logic                  rem_trivial;
	logic [OUT_W-1:0]      quo_sat;
	logic [OUT_W-1:0]      sd_fix;
	logic [OUT_W-1:0]      interp_val;
	logic                  res_load;

	stpg_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// Decode of the held command and of the current motion state.
	always_comb begin
		d_eff       = (dly_in_q == '0) ? DELAY_BITS'(1) : dly_in_q;
		d_ext       = OUT_W'(d_eff);
		den_eff     = (start_den_q == '0) ? MULT_W'(1) : start_den_q;
		elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
		done_inc    = done_steps_q + 1'b1;
		tick_start  = is_active_q && !pulse_on_q && (elapsed_inc >= cur_delay_q);
		tick_end    = is_active_q && pulse_on_q && (elapsed_inc >= OUT_W'(pulse_w_q));
		tick_finish = tick_end && !endless_q && (done_inc >= target_q);
		tick_recompute = tick_end && !endless_q && (done_inc < target_q);

		// Ramp length from a step count: min(default, count / 2), at least one.
		half_n   = cnt_in_q >> 1;
		ramp_min = (half_n < COUNT_BITS'(ramp_def_q)) ? half_n[RAMP_W-1:0] : ramp_def_q;
		ramp_set = (ramp_min == '0) ? RAMP_W'(1) : ramp_min;

		// Armed target saturates at all ones.
		arm_sum    = {1'b0, done_steps_q} + {1'b0, cnt_in_q};
		arm_target = arm_sum[COUNT_BITS] ? COUNT_ALL : arm_sum[COUNT_BITS-1:0];

		// Progress into the acceleration and deceleration ramps.
		r_eff    = (ramp_len_q == '0) ? RAMP_W'(1) : ramp_len_q;
		acc_prog = (done_steps_q > COUNT_BITS'(r_eff)) ? r_eff : done_steps_q[RAMP_W-1:0];
		rem_full = (target_q > done_steps_q) ? target_q - done_steps_q : '0;
		rem_prog = (rem_full > COUNT_BITS'(r_eff)) ? r_eff : rem_full[RAMP_W-1:0];

		nom_ext     = OUT_W'(nominal_q);
		sd_above    = start_delay_q > nom_ext;
		delta       = start_delay_q - nom_ext;
		acc_trivial = (acc_prog >= r_eff) || !sd_above;
		rem_trivial = (rem_prog >= r_eff) || !sd_above;

		// Start delay: saturate the quotient, keep it above the nominal delay.
		quo_sat = (md_rsp.quo[MD_P_W-1:OUT_W] != '0) ? '1 : md_rsp.quo[OUT_W-1:0];
		if (quo_sat > nom_ext) begin
			sd_fix = quo_sat;
		end else if (nom_ext == '1) begin
			sd_fix = '1;
		end else begin
			sd_fix = nom_ext + 1'b1;
		end

		interp_val = start_delay_q - md_rsp.quo[OUT_W-1:0];
		res_load   = (state_q == ST_OUT) && (!res_valid_q || res.ready);
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and requests to the shared unit.
	always_comb begin
		state_d = state_q;
		md_req  = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_OUT;
				case (op_q)
					OP_TICK: begin
						if (tick_recompute) begin
							state_d = ST_RC_ACC;
						end
					end
					OP_START_PROF: begin
						if (!is_active_q && cnt_in_q != '0) begin
							md_req.start = 1'b1;
							md_req.a     = MD_A_W'(d_eff);
							md_req.b     = MD_B_W'(start_num_q);
							md_req.c     = MD_B_W'(den_eff);
							state_d      = ST_WAIT_START;
						end
					end
					OP_ARM_STOP: begin
						if (is_active_q && cnt_in_q != '0) begin
							state_d = ST_RC_ACC;
						end
					end
					default: state_d = ST_OUT;
				endcase
			end
			ST_WAIT_START: begin
				if (md_rsp.done) begin
					state_d = ST_RC_ACC;
				end
			end
			ST_RC_ACC: begin
				md_req.a = delta;
				md_req.b = acc_prog;
				md_req.c = r_eff;
				if (acc_trivial) begin
					state_d = ST_RC_REM;
				end else begin
					md_req.start = 1'b1;
					state_d      = ST_WAIT_ACC;
				end
			end
			ST_WAIT_ACC: begin
				if (md_rsp.done) begin
					state_d = ST_RC_REM;
				end
			end
			ST_RC_REM: begin
				md_req.a = delta;
				md_req.b = rem_prog;
				md_req.c = r_eff;
				if (target_q == COUNT_ALL || rem_trivial) begin
					state_d = ST_FINISH;
				end else begin
					md_req.start = 1'b1;
					state_d      = ST_WAIT_REM;
				end
			end
			ST_WAIT_REM: begin
				if (md_rsp.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_OUT;
			ST_OUT: begin
				if (!res_valid_q || res.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_num_q <= RST_START_NUM;
			start_den_q <= RST_START_DEN;
			ramp_def_q  <= RST_RAMP_LEN;
			pulse_w_q   <= RST_PULSE_W;
			act_level_q <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_START_NUM: start_num_q <= cfg.data[MULT_W-1:0];
				CFG_START_DEN: start_den_q <= cfg.data[MULT_W-1:0];
				CFG_RAMP_LEN:  ramp_def_q  <= cfg.data[RAMP_W-1:0];
				CFG_PULSE_W:   pulse_w_q   <= cfg.data[PW_W-1:0];
				CFG_ACT_LEVEL: act_level_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Held command fields, cast to the working widths on transfer.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_q     <= cmd.op;
			cnt_in_q <= COUNT_BITS'(cmd.step_count);
			dly_in_q <= DELAY_BITS'(cmd.delay_us);
		end
	end

	// Motion state updates per sequencer step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_active_q   <= 1'b0;
			pulse_on_q    <= 1'b0;
			endless_q     <= 1'b0;
			target_q      <= '0;
			done_steps_q  <= '0;
			nominal_q     <= RST_NOM_DELAY;
			cur_delay_q   <= RST_DELAY;
			start_delay_q <= RST_DELAY;
			ramp_len_q    <= RAMP_W'(1);
			elapsed_q     <= '0;
			total_q       <= '0;
			tgt_q         <= '0;
			status_q      <= CS_OK;
			move_done_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_EXEC: begin
					status_q    <= CS_OK;
					move_done_q <= 1'b0;
					case (op_q)
						OP_TICK: begin
							if (is_active_q) begin
								elapsed_q <= tick_start ? '0 : elapsed_inc;
								if (tick_start) begin
									pulse_on_q <= 1'b1;
								end
								if (tick_end) begin
									pulse_on_q   <= 1'b0;
									done_steps_q <= done_inc;
									total_q      <= total_q + 1'b1;
								end
								if (tick_finish) begin
									is_active_q <= 1'b0;
									endless_q   <= 1'b0;
									move_done_q <= 1'b1;
								end
							end
						end
						OP_START_PROF: begin
							if (is_active_q) begin
								status_q <= CS_BUSY;
							end else if (cnt_in_q == '0) begin
								status_q <= CS_IGNORED;
							end else begin
								is_active_q  <= 1'b1;
								pulse_on_q   <= 1'b0;
								endless_q    <= 1'b0;
								target_q     <= cnt_in_q;
								done_steps_q <= '0;
								nominal_q    <= d_eff;
								cur_delay_q  <= d_ext;
								ramp_len_q   <= (cnt_in_q != COUNT_ALL) ? ramp_set : ramp_def_q;
								elapsed_q    <= '0;
							end
						end
						OP_START_CONT: begin
							if (is_active_q) begin
								status_q <= CS_BUSY;
							end else begin
								is_active_q   <= 1'b1;
								pulse_on_q    <= 1'b0;
								endless_q     <= 1'b1;
								target_q      <= '0;
								done_steps_q  <= '0;
								nominal_q     <= d_eff;
								cur_delay_q   <= d_ext;
								start_delay_q <= d_ext;
								ramp_len_q    <= '0;
								elapsed_q     <= '0;
							end
						end
						OP_ARM_STOP: begin
							if (!is_active_q) begin
								status_q <= CS_IGNORED;
							end else if (cnt_in_q == '0) begin
								is_active_q <= 1'b0;
								pulse_on_q  <= 1'b0;
								endless_q   <= 1'b0;
							end else begin
								target_q   <= arm_target;
								endless_q  <= 1'b0;
								ramp_len_q <= ramp_set;
							end
						end
						OP_STOP: begin
							is_active_q <= 1'b0;
							pulse_on_q  <= 1'b0;
							endless_q   <= 1'b0;
						end
						default: ;
					endcase
				end
				ST_WAIT_START: begin
					if (md_rsp.done) begin
						start_delay_q <= sd_fix;
					end
				end
				ST_RC_ACC: tgt_q <= nom_ext;
				ST_WAIT_ACC, ST_WAIT_REM: begin
					if (md_rsp.done && interp_val > tgt_q) begin
						tgt_q <= interp_val;
					end
				end
				ST_FINISH: cur_delay_q <= tgt_q;
				default: ;
			endcase
		end
	end

	// Result register: holds a finished result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_pin_q     <= pulse_on_q ? act_level_q : ~act_level_q;
			res_running_q <= is_active_q;
			res_done_q    <= move_done_q;
			res_status_q  <= status_q;
			res_steps_q   <= OUT_W'(done_steps_q);
			res_delay_q   <= cur_delay_q;
			res_total_q   <= total_q;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.step_pin       = res_pin_q;
	assign res.running        = res_running_q;
	assign res.move_done      = res_done_q;
	assign res.cmd_status     = res_status_q;
	assign res.steps_done     = res_steps_q;
	assign res.delay_now      = res_delay_q;
	assign res.lifetime_steps = res_total_q;

`ifndef SYNTHESIS
	// A pulse or a continuous run never exists without an active move.
	a_pulse_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		(pulse_on_q || endless_q) |-> is_active_q)
		else $error("pulse or endless mode set while no move is active");

	// The shared unit only completes while the sequencer waits for it.
	a_md_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> (state_q == ST_WAIT_START || state_q == ST_WAIT_ACC ||
			state_q == ST_WAIT_REM))
		else $error("multiply-divide result arrived outside a wait state");

	// An accepted command is decoded in the very next cycle.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> state_q == ST_EXEC)
		else $error("accepted command not decoded next cycle");

	// A completed move always leaves the motion inactive.
	a_done_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && move_done_q) |-> !is_active_q)
		else $error("move reported done while still active");
`endif

endmodule

[rtl/core/stpg_muldiv.sv]
// Shared iterative multiply-divide unit: quotient of a * b / c, one multiplier bit
// per cycle followed by one quotient bit per cycle (restoring division).
// Depends on stpg_pkg for the request and response structs.
module stpg_muldiv (
	input  logic             clk,
	input  logic             arst_n,
	input  stpg_pkg::md_req_t req,
	output stpg_pkg::md_rsp_t rsp
);
	import stpg_pkg::*;

	md_state_t           state_q;
	logic [MD_CNT_W-1:0] cnt_q;
	logic [MD_P_W-1:0]   acc_q;
	logic [MD_P_W-1:0]   mcand_q;
	logic [MD_B_W-1:0]   mplier_q;
	logic [MD_B_W-1:0]   divisor_q;
	logic [MD_B_W-1:0]   rem_q;
	logic [MD_P_W-1:0]   dvd_q;
	logic                done_q;

	logic [MD_P_W-1:0]   acc_nxt;
	logic [MD_B_W:0]     trial;
	logic                trial_ge;
	logic [MD_B_W:0]     trial_sub;

	// Shift-and-add step and restoring division step.
	always_comb begin
		acc_nxt   = mplier_q[0] ? acc_q + mcand_q : acc_q;
		trial     = {rem_q, dvd_q[MD_P_W-1]};
		trial_ge  = trial >= {1'b0, divisor_q};
		trial_sub = trial - {1'b0, divisor_q};
	end

	// Control: iteration counter, phase and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MD_IDLE: begin
					if (req.start) begin
						state_q <= MD_MUL;
						cnt_q   <= '0;
					end
				end
				MD_MUL: begin
					if (cnt_q == MD_CNT_W'(MD_B_W - 1)) begin
						state_q <= MD_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				MD_DIV: begin
					if (cnt_q == MD_CNT_W'(MD_P_W - 1)) begin
						state_q <= MD_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= MD_IDLE;
			endcase
		end
	end

	// Datapath: product accumulation, then the quotient shifts into the dividend.
	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (req.start) begin
					acc_q     <= '0;
					mcand_q   <= MD_P_W'(req.a);
					mplier_q  <= req.b;
					divisor_q <= req.c;
				end
			end
			MD_MUL: begin
				acc_q    <= acc_nxt;
				mcand_q  <= {mcand_q[MD_P_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[MD_B_W-1:1]};
				if (cnt_q == MD_CNT_W'(MD_B_W - 1)) begin
					dvd_q <= acc_nxt;
					rem_q <= '0;
				end
			end
			MD_DIV: begin
				rem_q <= trial_ge ? trial_sub[MD_B_W-1:0] : trial[MD_B_W-1:0];
				dvd_q <= {dvd_q[MD_P_W-2:0], trial_ge};
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.quo  = dvd_q;

endmodule
